>>> rtl/kqt_pkg.sv
// Shared types and constants for the keyed quantity table.
package kqt_pkg;

    localparam int unsigned DEF_ENTRIES = 64;
    localparam int KEY_W   = 32;
    localparam int QTY_W   = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_LOOKUP = 2'd3
    } kqt_op_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_FULL    = 2'd3
    } kqt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } kqt_state_t;

    typedef struct packed {
        logic             key_en;
        logic             qty_en;
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
    } kqt_wr_t;

endpackage

>>> rtl/kqt_req_if.sv
// Request channel: operation, key and quantity with valid/ready.
interface kqt_req_if;
    logic                     valid;
    logic                     ready;
    logic [kqt_pkg::OP_W-1:0] operation;
    logic [kqt_pkg::KEY_W-1:0] item_key;
    logic [kqt_pkg::QTY_W-1:0] item_quantity;

    modport source (output valid, output operation, output item_key, output item_quantity,
                    input ready);
    modport sink   (input valid, input operation, input item_key, input item_quantity,
                    output ready);
endinterface

>>> rtl/kqt_rsp_if.sv
// Response channel: status, index, quantity and count with valid/ready.
interface kqt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [kqt_pkg::STAT_W-1:0]  status;
    logic [kqt_pkg::INDEX_W-1:0] found_index;
    logic [kqt_pkg::QTY_W-1:0]   found_quantity;
    logic [kqt_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output found_index, output found_quantity,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_index, input found_quantity,
                    input entry_count, output ready);
endinterface

>>> rtl/keyed_quantity_table.sv
// Keyed quantity table: unsorted key/quantity store with linear search and swap-remove.
// Insert, or any request on an empty table, goes straight to S_DONE; lookup or update
// searches to the hit, remove then moves the last entry in; a miss scans all entries.
// The search reads one slot per cycle through the single memory read port.
// One word in flight at a time; a new word is taken while the last response waits.
// Reset clears the fill count and control; the memories keep stale data, never read.
module keyed_quantity_table #(
    parameter int unsigned ENTRIES = kqt_pkg::DEF_ENTRIES
) (
    input logic       clk,
    input logic       rst_n,
    kqt_req_if.sink   req,
    kqt_rsp_if.source rsp
);
    import kqt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    kqt_state_t        state_reg, state_next;
    kqt_op_t           op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [QTY_W-1:0]  qty_reg, qty_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_slot_reg, rd_slot_next;
    kqt_status_t       res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;
    logic [QTY_W-1:0]  res_qty_reg, res_qty_next;
    logic              out_valid_reg, out_valid_next;
    kqt_status_t       out_status_reg, out_status_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [QTY_W-1:0]  out_qty_reg, out_qty_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic              accept;
    kqt_op_t           req_op;
    logic              match;
    logic              last_cmp;
    logic              out_load;
    logic [CNT_W-1:0]  count_dec;
    logic [IDX_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    kqt_wr_t           mem_wr;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [QTY_W-1:0]  rd_qty;

    kqt_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .wr_addr (mem_wr_addr),
        .rd_addr (mem_rd_addr),
        .rd_key  (rd_key),
        .rd_qty  (rd_qty)
    );

    assign accept    = req.valid && req.ready;
    assign req_op    = kqt_op_t'(req.operation);
    assign match     = rd_valid_reg && (rd_key == key_reg);
    assign last_cmp  = rd_valid_reg && ((CNT_W'(rd_slot_reg) + CNT_W'(1)) == count_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign count_dec = count_reg - CNT_W'(1);
    assign idx_wide  = {INDEX_W'(0), res_index_reg};
    assign cnt_wide  = {COUNT_W'(0), count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_INSERT || count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    state_next = (op_reg == OP_REMOVE) ? S_MOVE_RD : S_DONE;
                end
                else if (last_cmp)
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE_RD: state_next = S_MOVE_WR;
            S_MOVE_WR: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        qty_next        = qty_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        rd_valid_next   = 1'b0;
        rd_slot_next    = rd_slot_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_qty_next    = res_qty_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                if (accept)
                begin
                    op_next  = req_op;
                    key_next = req.item_key;
                    qty_next = req.item_quantity;
                    res_status_next = STATUS_OK;
                    res_index_next  = '0;
                    res_qty_next    = '0;
                    if (req_op == OP_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            res_index_next = count_reg[IDX_W-1:0];
                            res_qty_next   = req.item_quantity;
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                end
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    res_index_next = rd_slot_reg;
                    res_qty_next   = (op_reg == OP_UPDATE) ? qty_reg : rd_qty;
                end
                else if (last_cmp)
                begin
                    res_status_next = STATUS_MISSING;
                end
                else
                begin
                    rd_valid_next = (ptr_reg != count_reg);
                    rd_slot_next  = ptr_reg[IDX_W-1:0];
                    if (ptr_reg != count_reg)
                    begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
            end
            S_MOVE_WR:
            begin
                count_next = count_dec;
            end
            default:
            begin
            end
        endcase
    end

    // response register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_qty_next    = out_qty_reg;
        out_count_next  = out_count_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_index_next  = idx_wide[INDEX_W-1:0];
            out_qty_next    = res_qty_reg;
            out_count_next  = cnt_wide[COUNT_W-1:0];
        end
    end

    // memory and port control
    always_comb
    begin
        mem_wr      = '0;
        mem_wr_addr = res_index_reg;
        mem_rd_addr = ptr_reg[IDX_W-1:0];
        req.ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                mem_wr_addr = count_reg[IDX_W-1:0];
                mem_wr.key  = req.item_key;
                mem_wr.qty  = req.item_quantity;
                if (accept && req_op == OP_INSERT && count_reg != FULL_COUNT)
                begin
                    mem_wr.key_en = 1'b1;
                    mem_wr.qty_en = 1'b1;
                end
            end
            S_SEARCH:
            begin
                mem_wr_addr   = rd_slot_reg;
                mem_wr.qty    = qty_reg;
                mem_wr.qty_en = match && (op_reg == OP_UPDATE);
            end
            S_MOVE_RD:
            begin
                mem_rd_addr = count_dec[IDX_W-1:0];
            end
            S_MOVE_WR:
            begin
                mem_wr.key    = rd_key;
                mem_wr.qty    = rd_qty;
                mem_wr.key_en = 1'b1;
                mem_wr.qty_en = 1'b1;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_index    = out_index_reg;
    assign rsp.found_quantity = out_qty_reg;
    assign rsp.entry_count    = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        qty_reg        <= qty_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_qty_reg    <= res_qty_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_qty_reg    <= out_qty_next;
        out_count_reg  <= out_count_next;
    end

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count above table size");

    search_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_op != OP_INSERT && count_reg != '0) |=> state_reg == S_SEARCH)
        else $error("search not started");

    remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE_WR |=> count_reg == $past(count_dec))
        else $error("remove did not decrement count");

    compare_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && rd_valid_reg) |-> CNT_W'(rd_slot_reg) < count_reg)
        else $error("compare beyond fill count");

endmodule

>>> rtl/kqt_store.sv
// Key and quantity memories: one write port, one registered read port.
module kqt_store #(
    parameter int unsigned ENTRIES = kqt_pkg::DEF_ENTRIES,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                       clk,
    input  kqt_pkg::kqt_wr_t           wr,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [kqt_pkg::KEY_W-1:0]  rd_key,
    output logic [kqt_pkg::QTY_W-1:0]  rd_qty
);
    import kqt_pkg::*;

    logic [KEY_W-1:0] key_mem_reg [ENTRIES];
    logic [QTY_W-1:0] qty_mem_reg [ENTRIES];
    logic [KEY_W-1:0] rd_key_reg;
    logic [QTY_W-1:0] rd_qty_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_mem_reg[wr_addr] <= wr.key;
        end
        rd_key_reg <= key_mem_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.qty_en)
        begin
            qty_mem_reg[wr_addr] <= wr.qty;
        end
        rd_qty_reg <= qty_mem_reg[rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign rd_qty = rd_qty_reg;

endmodule
